// File: design/chrp_pkg.sv
// Shared constants for the hash ring backend picker.
`default_nettype none
package chrp_pkg;
	localparam int RING_SIZE_DEF    = 1024;
	localparam int MAX_BACKENDS_DEF = 64;
	localparam logic [16:0] WARMUP_ONE = 17'd65536;

	localparam logic [1:0] REG_RING_POINTS    = 2'd0;
	localparam logic [1:0] REG_BACKEND_COUNT  = 2'd1;
	localparam logic [1:0] REG_WARMUP_DEFAULT = 2'd2;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_WRITE  = 1'b1;

	localparam logic [1:0] MODE_CHOSEN_HEALTHY = 2'd0;
	localparam logic [1:0] MODE_IGNORE_HEALTH  = 2'd1;
	localparam logic [1:0] MODE_ALL_HEALTHY    = 2'd2;

	localparam logic [1:0] STATUS_CHOSEN   = 2'd0;
	localparam logic [1:0] STATUS_FALLBACK = 2'd1;
	localparam logic [1:0] STATUS_NONE     = 2'd2;

	localparam logic [1:0] PHASE_ALT  = 2'd0;
	localparam logic [1:0] PHASE_MAIN = 2'd1;
	localparam logic [1:0] PHASE_WARM = 2'd2;
endpackage
`default_nettype wire

// File: design/consistent_hash_ring_pick.sv
// Consistent hash ring backend picker: ring memory, search and walk sequencer.
// A write item gives no result. A lookup is accepted, then binary-searches the ring
// (up to log2(ring_points)+1 probes, each a read and one or two point checks), walks
// entries (a read and a check each) until a pick or a run-out, then loads the output.
// Items are taken one at a time; the next item is taken once the result is loaded.
// Reset (arst_n low) clears the sequencer, output valid and the registers to
// ring_points 1, backend_count 0, warmup_default 0; the ring is not cleared.
`default_nettype none
module consistent_hash_ring_pick #(
	parameter int RING_SIZE    = chrp_pkg::RING_SIZE_DEF,
	parameter int MAX_BACKENDS = chrp_pkg::MAX_BACKENDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [31:0] key,
	input  wire logic [5:0]  alt,
	input  wire logic [1:0]  health_mode,
	input  wire logic [63:0] health_mask,
	input  wire logic        use_default_warmup,
	input  wire logic [16:0] warmup,
	input  wire logic [15:0] random_value,
	input  wire logic [9:0]  entry_index,
	input  wire logic [31:0] entry_point,
	input  wire logic [5:0]  entry_backend,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       backend,
	output logic [1:0]       status
);
	import chrp_pkg::*;

	localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
	localparam int NW = $clog2(RING_SIZE + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SRD  = 7'b0000010, // issue probe read
		S_SP   = 7'b0000100, // check probe point
		S_SN   = 7'b0001000, // check point after probe
		S_WRD  = 7'b0010000, // issue walk read
		S_WCHK = 7'b0100000, // check walked entry
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [10:0] ring_points_q;
	logic [6:0]  backend_count_q;
	logic [16:0] warmup_default_q;

	// ring memory
	logic [31:0] ring_point_mem [RING_SIZE];
	logic [5:0]  ring_backend_mem [RING_SIZE];
	logic [31:0] rd_point_q;
	logic [5:0]  rd_backend_q;
	logic [AW-1:0] rd_addr;

	// latched lookup
	logic [NW-1:0] n_q;
	logic [6:0]    bc_q;
	logic [5:0]    alt_q;
	logic [1:0]    mode_q;
	logic [63:0]   mask_q;
	logic          warm_nz_q;
	logic          swap_q;
	logic [31:0]   key_q;

	// search
	logic [NW-1:0] lo_q, hi_q;
	logic [AW-1:0] i_q;
	logic [NW:0]   mid_sum;
	logic [AW-1:0] mid;

	// walk
	logic [AW-1:0]           pos_q;
	logic [NW-1:0]           visits_q;
	logic [MAX_BACKENDS-1:0] picked_q;
	logic [6:0]              cnt_q;
	logic [5:0]              skip_q;
	logic                    need_q;
	logic [1:0]              phase_q;
	logic [5:0]              prev_q, last_q, chosen_q;
	logic                    prev_v_q, last_v_q;

	// result
	logic [5:0] res_backend_q;
	logic [1:0] res_status_q;

	// lookup setup, combinational
	logic [NW-1:0] n_c;
	logic [6:0]    bc_c;
	logic [5:0]    alt_c;
	logic [1:0]    mode_c;
	logic [16:0]   warm_sel, warm_c;

	// walk check, combinational
	logic [63:0] picked_ext;
	logic        hit, ok, chose, dec;

	assign in_ready = (state_q == S_IDLE);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = AW'(mid_sum >> 1);

	always_comb begin
		if (ring_points_q == 11'd0) n_c = NW'(1);
		else if (32'(ring_points_q) > RING_SIZE) n_c = NW'(RING_SIZE);
		else n_c = NW'(ring_points_q);
		if (32'(backend_count_q) > MAX_BACKENDS) bc_c = 7'(MAX_BACKENDS);
		else bc_c = backend_count_q;
		if ({1'b0, alt} > bc_c - 7'd1) alt_c = 6'(bc_c - 7'd1);
		else alt_c = alt;
		mode_c   = (health_mode == 2'd3) ? MODE_CHOSEN_HEALTHY : health_mode;
		warm_sel = use_default_warmup ? warmup_default_q : warmup;
		warm_c   = (warm_sel > WARMUP_ONE) ? WARMUP_ONE : warm_sel;
	end

	always_comb begin
		picked_ext = 64'(picked_q);
		hit   = ({1'b0, rd_backend_q} < bc_q) && !picked_ext[rd_backend_q];
		ok    = mask_q[rd_backend_q];
		chose = (ok || !need_q) && (skip_q == 6'd0);
		dec   = ok || !need_q;
	end

	always_comb begin
		unique case (state_q)
			S_SRD:   rd_addr = mid;
			S_SP:    rd_addr = i_q + AW'(1);
			default: rd_addr = pos_q;
		endcase
	end

	// ring memory: write on an accepted write item with an in-range index, read every cycle
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && func == FUNC_WRITE && 32'(entry_index) < RING_SIZE) begin
			ring_point_mem[AW'(entry_index)]   <= entry_point;
			ring_backend_mem[AW'(entry_index)] <= entry_backend;
		end
		rd_point_q   <= ring_point_mem[rd_addr];
		rd_backend_q <= ring_backend_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_points_q    <= 11'd1;
			backend_count_q  <= 7'd0;
			warmup_default_q <= 17'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RING_POINTS:    ring_points_q    <= cfg_wdata[10:0];
				REG_BACKEND_COUNT:  backend_count_q  <= cfg_wdata[6:0];
				REG_WARMUP_DEFAULT: warmup_default_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one loads this cycle
			if (out_valid && out_ready && state_q != S_OUT) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && func == FUNC_LOOKUP) begin
						n_q       <= n_c;
						bc_q      <= bc_c;
						alt_q     <= alt_c;
						mode_q    <= mode_c;
						mask_q    <= health_mask;
						warm_nz_q <= (warm_c != 17'd0);
						swap_q    <= ({1'b0, random_value} <= warm_c);
						key_q     <= key;
						lo_q      <= '0;
						hi_q      <= n_c;
						picked_q  <= '0;
						cnt_q     <= 7'd0;
						prev_v_q  <= 1'b0;
						last_v_q  <= 1'b0;
						if (bc_c == 7'd0) begin
							res_backend_q <= 6'd0;
							res_status_q  <= STATUS_NONE;
							state_q       <= S_OUT;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					i_q     <= mid;
					state_q <= S_SP;
				end
				S_SP: begin
					state_q <= S_WRD;
					if (rd_point_q == key_q) begin
						pos_q <= i_q;
					end else if (NW'(i_q) == n_q - NW'(1)) begin
						pos_q <= i_q;
					end else if (rd_point_q > key_q) begin
						if (i_q == '0 || hi_q == NW'(i_q)) begin
							pos_q <= i_q;
						end else begin
							hi_q    <= NW'(i_q);
							state_q <= S_SRD;
						end
					end else begin
						state_q <= S_SN;
					end
				end
				S_SN: begin
					state_q <= S_WRD;
					if (rd_point_q >= key_q) begin
						pos_q <= i_q + AW'(1);
					end else if (lo_q == NW'(i_q)) begin
						pos_q <= i_q;
					end else begin
						lo_q    <= NW'(i_q);
						state_q <= S_SRD;
					end
				end
				S_WRD: begin
					if (cnt_q >= bc_q || visits_q >= n_q) begin
						// walk failed: fall back except in the warmup probe
						state_q <= S_OUT;
						if (phase_q == PHASE_WARM) begin
							res_backend_q <= chosen_q;
							res_status_q  <= STATUS_CHOSEN;
						end else if (prev_v_q) begin
							res_backend_q <= prev_q;
							res_status_q  <= STATUS_FALLBACK;
						end else begin
							res_backend_q <= 6'd0;
							res_status_q  <= STATUS_NONE;
						end
					end else begin
						visits_q <= visits_q + NW'(1);
						state_q  <= S_WCHK;
					end
				end
				S_WCHK: begin
					state_q <= S_WRD;
					if (hit) begin
						picked_q <= picked_q | MAX_BACKENDS'(64'd1 << rd_backend_q);
						cnt_q    <= cnt_q + 7'd1;
						if (chose) begin
							if (last_v_q) begin
								prev_q   <= last_q;
								prev_v_q <= 1'b1;
							end
							last_q   <= rd_backend_q;
							last_v_q <= 1'b1;
						end else if (ok) begin
							prev_q   <= rd_backend_q;
							prev_v_q <= 1'b1;
						end
						if (dec) skip_q <= skip_q - 6'd1;
					end
					if (hit && chose) begin
						// call done; hold the walk position
						visits_q <= '0;
						skip_q   <= 6'd0;
						unique case (phase_q)
							PHASE_ALT: begin
								phase_q <= PHASE_MAIN;
								need_q  <= (mode_q != MODE_IGNORE_HEALTH);
							end
							PHASE_MAIN: begin
								chosen_q <= rd_backend_q;
								if (alt_q == 6'd0 && mode_q != MODE_IGNORE_HEALTH && warm_nz_q) begin
									phase_q <= PHASE_WARM;
									need_q  <= 1'b1;
								end else begin
									res_backend_q <= rd_backend_q;
									res_status_q  <= STATUS_CHOSEN;
									state_q       <= S_OUT;
								end
							end
							default: begin
								res_backend_q <= swap_q ? rd_backend_q : chosen_q;
								res_status_q  <= STATUS_CHOSEN;
								state_q       <= S_OUT;
							end
						endcase
					end else if (!(hit && chose)) begin
						pos_q <= (NW'(pos_q) + NW'(1) >= n_q) ? '0 : pos_q + AW'(1);
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						backend   <= res_backend_q;
						status    <= res_status_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// walk setup in every probe check state; the values set as the search lands hold
			if ((state_q == S_SP || state_q == S_SN) && state_q != S_SRD) begin
				visits_q <= '0;
				if (alt_q != 6'd0) begin
					phase_q <= PHASE_ALT;
					skip_q  <= alt_q - 6'd1;
					need_q  <= (mode_q == MODE_ALL_HEALTHY);
				end else begin
					phase_q <= PHASE_MAIN;
					skip_q  <= 6'd0;
					need_q  <= (mode_q != MODE_IGNORE_HEALTH);
				end
			end
		end
	end
endmodule
`default_nettype wire
